// ===== rtl/servo_keyframe_interpolator_defines.svh =====
// Assertion macros for the servo keyframe interpolator.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SERVO_KEYFRAME_INTERPOLATOR_DEFINES_SVH
`define SERVO_KEYFRAME_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define SKI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define SKI_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define SKI_ASSERT(lbl, clk, rstn, prop)
`define SKI_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/ski_pkg.sv =====
// Shared types and constants for the servo keyframe interpolator.
// No dependencies.
package ski_pkg;
  localparam int unsigned NumServos = 8;
  localparam int unsigned AngW = 8;

  // Reciprocal multipliers: x/3 = (x*171)>>9 for x < 512,
  // x/100 = (x*2684355)>>28 for x below six million
  localparam int unsigned Recip3 = 171;
  localparam int unsigned Recip3Shift = 9;
  localparam int unsigned Recip100 = 2684355;
  localparam int unsigned Recip100Shift = 28;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_TICK = 1'b1} cmd_e;
  typedef enum logic {REG_SPEED = 1'b0, REG_BASE_DELAY = 1'b1} reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_TICKS, ST_READY, ST_STEP, ST_OUT
  } state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] target_0;
    logic [7:0] target_1;
    logic [7:0] target_2;
    logic [7:0] target_3;
    logic [7:0] target_4;
    logic [7:0] target_5;
    logic [7:0] target_6;
    logic [7:0] target_7;
    logic [15:0] duration_ms;
  } in_req_t;

  typedef struct packed {
    logic [7:0] position_0;
    logic [7:0] position_1;
    logic [7:0] position_2;
    logic [7:0] position_3;
    logic [7:0] position_4;
    logic [7:0] position_5;
    logic [7:0] position_6;
    logic [7:0] position_7;
    logic [7:0] write_mask;
    logic       keyframe_done;
  } out_req_t;

  // Lane control: start a division, lanes report when finished.
  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } lane_ctl_t;
endpackage

// ===== rtl/ski_lane.sv =====
// One interpolation lane: restoring divider giving trunc(num/den).
// Depends on ski_pkg and the assertion macros header.
`include "servo_keyframe_interpolator_defines.svh"
module ski_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ski_pkg::lane_ctl_t ctl_i,
  output logic              busy_o,
  output logic [23:0]       quot_o
);
  logic [23:0] q_q, q_d;
  logic [16:0] r_q, r_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  // Shift in one numerator bit per cycle
  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {r_q[15:0], q_q[23]};
    if (ctl_i.start) begin
      q_d = ctl_i.num; r_d = '0; den_d = ctl_i.den; cnt_d = 5'd24; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q}; q_d = {q_q[22:0], 1'b1};
      end else begin
        r_d = trial; q_d = {q_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

  `SKI_ASSERT(a_cnt_busy, clk_i, rst_ni, (busy_q == (cnt_q != 5'd0)))
  `SKI_ASSERT(a_start_busy, clk_i, rst_ni, ctl_i.start |=> busy_q)
  `SKI_ASSERT(a_rem_small, clk_i, rst_ni, busy_q |-> (r_q < {1'b0, den_q}))
endmodule

// ===== rtl/servo_keyframe_interpolator.sv =====
// Top level: keyframe load scaling, eight divider lanes and result merge.
// Depends on ski_pkg, ski_lane and the assertion macros header.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid_i/stall_o | ski_pkg::in_req_t
//  out     | out | out_valid_o/stall_i| ski_pkg::out_req_t
//  cfg     | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A load scales the duration by reciprocal multiply, then runs one
// 24-step divide in lane 0 for the tick count.
// On a tick all eight lanes divide at once, 24 steps each. The final
// tick skips the divide and returns the targets from the output state.
// Reset clears control state; speed 80, base delay 3, starts at 90 degrees.
// One request in flight; input stalls while busy and until the result register is taken.
`include "servo_keyframe_interpolator_defines.svh"
module servo_keyframe_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ski_pkg::in_req_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ski_pkg::out_req_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);
  localparam int unsigned N = ski_pkg::NumServos;

  ski_pkg::state_e st_q, st_d;
  logic [7:0]  speed_q, bd_q;
  logic [7:0]  start_q [N];
  logic [7:0]  tgt_q   [N];
  logic [14:0] tidx_q, ttot_q;
  logic [15:0] span_q;
  logic        act_q;
  logic [23:0] prod_q;
  logic        ovalid_q;
  ski_pkg::out_req_t odata_q;

  ski_pkg::lane_ctl_t ctl [N];
  logic        busy [N];
  logic [23:0] quot [N];
  logic        any_busy;

  logic        acc;
  logic [6:0]  pct;
  logic [6:0]  pct_diff;
  logic [14:0] pct_mul;
  logic [45:0] scl_mul;
  logic [23:0] scl_q100;
  logic [22:0] tnext;
  logic [15:0] tcl, spn;
  logic [7:0]  delta [N];
  logic [14:0] tinc;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ski_pkg::ST_IDLE) || ovalid_q;
  assign tinc = tidx_q + 15'd1;

  // Speed percent: trunc((110 - speed) / 3) by reciprocal, floor of 5
  always_comb begin
    pct_diff = 7'(8'd110 - speed_q);
    pct_mul = 15'(pct_diff) * 15'(ski_pkg::Recip3);
    pct = 7'd5;
    if (speed_q < 8'd95) pct = 7'(pct_mul >> ski_pkg::Recip3Shift);
  end

  // Scaled duration divided by 100
  assign scl_mul = 46'(prod_q) * 46'(ski_pkg::Recip100);
  assign scl_q100 = 24'(scl_mul >> ski_pkg::Recip100Shift);

  // Elapsed time for this tick, saturated at span
  always_comb begin
    spn = (span_q == 16'd0) ? 16'd1 : span_q;
    tnext = 23'(tinc) * 23'(bd_q);
    tcl = (tnext > 23'(spn)) ? spn : tnext[15:0];
  end

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < N; i++) begin
      any_busy = any_busy | busy[i];
      delta[i] = (tgt_q[i] > start_q[i]) ? tgt_q[i] - start_q[i] : start_q[i] - tgt_q[i];
    end
  end

  // Lane control: lane 0 also serves the tick count of a load
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i].start = (st_q == ski_pkg::ST_READY);
      ctl[i].num   = 24'(prod_q[15:0]) * 24'(delta[i]);
      ctl[i].den   = spn;
    end
    ctl[0].start = 1'b0;
    ctl[0].num = '0;
    ctl[0].den = 16'd1;
    if (st_q == ski_pkg::ST_TICKS) begin
      ctl[0].start = 1'b1;
      ctl[0].num = prod_q;
      ctl[0].den = 16'(bd_q);
    end else if (st_q == ski_pkg::ST_READY) begin
      ctl[0].start = 1'b1;
      ctl[0].num = 24'(prod_q[15:0]) * 24'(delta[0]);
      ctl[0].den = spn;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    ski_lane u_lane (.clk_i, .rst_ni, .ctl_i(ctl[g]), .busy_o(busy[g]), .quot_o(quot[g]));
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ski_pkg::ST_IDLE: begin
        if (acc && in_data_i.command == ski_pkg::CMD_LOAD) st_d = ski_pkg::ST_SCALE;
        else if (acc && act_q) st_d = (tinc >= ttot_q) ? ski_pkg::ST_OUT : ski_pkg::ST_READY;
      end
      ski_pkg::ST_SCALE: st_d = ski_pkg::ST_TICKS;
      ski_pkg::ST_TICKS: st_d = ski_pkg::ST_STEP;
      ski_pkg::ST_READY: st_d = ski_pkg::ST_STEP;
      ski_pkg::ST_STEP:  if (!any_busy) st_d = act_q ? ski_pkg::ST_OUT : ski_pkg::ST_IDLE;
      ski_pkg::ST_OUT:   st_d = ski_pkg::ST_IDLE;
      default:           st_d = ski_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ski_pkg::ST_IDLE;
      speed_q <= 8'd80; bd_q <= 8'd3;
      tidx_q <= '0; ttot_q <= '0; span_q <= '0; act_q <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < N; i++) start_q[i] <= 8'd90;
    end else begin
      st_q <= st_d;
      // Clamp configuration writes
      if (cfg_we_i && cfg_idx_i == ski_pkg::REG_SPEED)
        speed_q <= (cfg_data_i < 8'd10) ? 8'd10 : (cfg_data_i > 8'd250) ? 8'd250 : cfg_data_i;
      if (cfg_we_i && cfg_idx_i == ski_pkg::REG_BASE_DELAY)
        bd_q <= (cfg_data_i == 8'd0) ? 8'd1 : cfg_data_i;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (st_q)
        ski_pkg::ST_IDLE: begin
          if (acc && in_data_i.command == ski_pkg::CMD_LOAD) begin
            act_q <= 1'b0;
          end else if (acc && act_q) begin
            tidx_q <= tinc;
          end
        end
        ski_pkg::ST_STEP: begin
          if (!any_busy && !act_q) begin
            // Tick count ready: finish load
            ttot_q <= (quot[0] == 24'd0) ? 15'd1 : quot[0][14:0];
            span_q <= 16'(((quot[0] == 24'd0) ? 24'd1 : quot[0]) * 24'(bd_q));
            tidx_q <= '0;
            act_q <= 1'b1;
          end else if (!any_busy) begin
            ovalid_q <= 1'b1;
          end
        end
        ski_pkg::ST_OUT: begin
          if (tidx_q >= ttot_q) begin
            ovalid_q <= 1'b1;
            act_q <= 1'b0;
            for (int i = 0; i < N; i++) start_q[i] <= tgt_q[i];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: targets, load arithmetic and the result register
  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.command == ski_pkg::CMD_LOAD) begin
      tgt_q[0] <= in_data_i.target_0; tgt_q[1] <= in_data_i.target_1;
      tgt_q[2] <= in_data_i.target_2; tgt_q[3] <= in_data_i.target_3;
      tgt_q[4] <= in_data_i.target_4; tgt_q[5] <= in_data_i.target_5;
      tgt_q[6] <= in_data_i.target_6; tgt_q[7] <= in_data_i.target_7;
    end
    if (st_q == ski_pkg::ST_SCALE) begin
      // total = max(scaled, bd), then add bd-1 for ceil
      prod_q <= ((scl_q100 < 24'(bd_q)) ? 24'(bd_q) : scl_q100) + 24'(bd_q) - 24'd1;
    end
    // Hold the scaled duration on a load, the elapsed time on a tick
    if (st_q == ski_pkg::ST_IDLE && acc) begin
      prod_q <= (in_data_i.command == ski_pkg::CMD_LOAD)
              ? 24'(in_data_i.duration_ms) * 24'(pct) : 24'(tcl);
    end
    if (st_q == ski_pkg::ST_STEP && !any_busy && act_q) begin
      logic [7:0] p [N];
      logic [7:0] m;
      m = '0;
      for (int i = 0; i < N; i++) begin
        p[i] = start_q[i];
        if (start_q[i] != tgt_q[i]) begin
          m[i] = 1'b1;
          p[i] = (tgt_q[i] > start_q[i]) ? start_q[i] + quot[i][7:0] : start_q[i] - quot[i][7:0];
        end
      end
      odata_q <= '{p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], m, 1'b0};
    end
    if (st_q == ski_pkg::ST_OUT && tidx_q >= ttot_q)
      odata_q <= '{tgt_q[0], tgt_q[1], tgt_q[2], tgt_q[3], tgt_q[4], tgt_q[5],
                   tgt_q[6], tgt_q[7], 8'hFF, 1'b1};
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;

  `SKI_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != ski_pkg::ST_IDLE) |-> !acc)
  `SKI_ASSERT(a_done_full, clk_i, rst_ni, (ovalid_q && odata_q.keyframe_done) |-> (odata_q.write_mask == 8'hFF))
  `SKI_ASSERT(a_done_idle, clk_i, rst_ni, (ovalid_q && odata_q.keyframe_done) |-> !act_q)
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the servo keyframe interpolator: directed table, then random
// keyframe sequences checked against a behavioral predictor. Depends on ski_pkg and servo_keyframe_interpolator.
module testbench;

  localparam int unsigned ItemsRandom = 1550;
  localparam int unsigned SettleCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ski_pkg::in_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ski_pkg::out_req_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  servo_keyframe_interpolator u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [7:0] start_ang[8];
  logic [7:0] goal_ang[8];
  logic [14:0] tick_idx;
  logic [14:0] tick_tot;
  logic [15:0] span_ms;
  bit kf_active;
  logic [7:0] speed_q;
  logic [7:0] delay_q;

  ski_pkg::out_req_t pending_q[$];
  int errors = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_results = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  typedef struct {
    ski_pkg::in_req_t req;
    bit typed;
    ski_pkg::out_req_t val;
  } row_t;

  function automatic ski_pkg::in_req_t mk_req(logic cmd, logic [63:0] tg, logic [15:0] dur);
    return {cmd, tg, dur};
  endfunction

  // Load latches targets and sizes the keyframe; tick advances toward the targets
  function automatic bit interpolate(ski_pkg::in_req_t r, output ski_pkg::out_req_t o);
    int pct, tot, bd, tk, t, sp, dl, mv;
    logic [7:0] pos[8];
    logic [7:0] tg[8];
    logic [7:0] mask;
    o = '0;
    tg = '{r.target_0, r.target_1, r.target_2, r.target_3,
           r.target_4, r.target_5, r.target_6, r.target_7};
    bd = (delay_q == 0) ? 1 : delay_q;
    if (r.command == ski_pkg::CMD_LOAD) begin
      goal_ang = tg;
      pct = (speed_q < 110) ? (110 - speed_q) / 3 : 0;
      if (pct < 5) pct = 5;
      tot = r.duration_ms * pct / 100;
      if (tot < bd) tot = bd;
      tk = (tot + bd - 1) / bd;
      tick_tot = tk[14:0];
      span_ms = 16'(tk * bd);
      tick_idx = '0;
      kf_active = 1;
      return 0;
    end
    if (!kf_active) return 0;
    tick_idx = tick_idx + 15'd1;
    mask = '0;
    if (tick_idx >= tick_tot) begin
      pos = goal_ang;
      start_ang = goal_ang;
      mask = 8'hFF;
      kf_active = 0;
      o.keyframe_done = 1'b1;
    end else begin
      sp = (span_ms == 0) ? 1 : span_ms;
      t = tick_idx * bd;
      if (t > sp) t = sp;
      for (int i = 0; i < 8; i++) begin
        if (start_ang[i] == goal_ang[i]) begin
          pos[i] = start_ang[i];
        end else begin
          dl = (goal_ang[i] > start_ang[i]) ? goal_ang[i] - start_ang[i]
                                            : start_ang[i] - goal_ang[i];
          mv = t * dl / sp;
          pos[i] = (goal_ang[i] > start_ang[i]) ? 8'(start_ang[i] + mv)
                                                : 8'(start_ang[i] - mv);
          mask[i] = 1'b1;
        end
      end
    end
    o.position_0 = pos[0]; o.position_1 = pos[1]; o.position_2 = pos[2];
    o.position_3 = pos[3]; o.position_4 = pos[4]; o.position_5 = pos[5];
    o.position_6 = pos[6]; o.position_7 = pos[7];
    o.write_mask = mask;
    return 1;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each taken result with the oldest expected position set
  always @(posedge clk_i) begin
    ski_pkg::out_req_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        check_field("position_0", e.position_0, out_data_o.position_0);
        check_field("position_1", e.position_1, out_data_o.position_1);
        check_field("position_2", e.position_2, out_data_o.position_2);
        check_field("position_3", e.position_3, out_data_o.position_3);
        check_field("position_4", e.position_4, out_data_o.position_4);
        check_field("position_5", e.position_5, out_data_o.position_5);
        check_field("position_6", e.position_6, out_data_o.position_6);
        check_field("position_7", e.position_7, out_data_o.position_7);
        check_field("write_mask", e.write_mask, out_data_o.write_mask);
        check_field("keyframe_done", e.keyframe_done, out_data_o.keyframe_done);
      end
    end
  end

  // Receiver stall: random, quiet stretch, or one long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 18);
    end
  end

  // Offer one request, wait for it to be taken, then maybe idle
  task automatic send_req(ski_pkg::in_req_t r, bit typed = 0, ski_pkg::out_req_t tv = '0);
    ski_pkg::out_req_t o;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (r.command == ski_pkg::CMD_LOAD) n_loads++; else n_ticks++;
    if (interpolate(r, o)) pending_q.push_back(typed ? tv : o);
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drain all results, let a load finish, then write one register
  task automatic write_reg(ski_pkg::reg_e idx, logic [7:0] val);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ski_pkg::REG_SPEED) speed_q = (val < 10) ? 8'd10 : (val > 250) ? 8'd250 : val;
    else delay_q = (val == 0) ? 8'd1 : val;
  endtask

  function automatic logic [63:0] rand_targets();
    logic [63:0] tg;
    for (int i = 0; i < 8; i++)
      tg[i*8 +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 180));
    return tg;
  endfunction

  initial begin
    row_t rows[$];
    int sent, n_tk, pick;
    logic [15:0] dur;
    logic [7:0] speeds[7] = '{8'd0, 8'd255, 8'd110, 8'd10, 8'd250, 8'd80, 8'd137};
    logic [7:0] delays[7] = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd3, 8'd2, 8'd20};

    speed_q = 8'd80;
    delay_q = 8'd3;
    foreach (start_ang[i]) begin
      start_ang[i] = 8'd90;
      goal_ang[i] = '0;
    end
    tick_idx = '0; tick_tot = '0; span_ms = '0; kf_active = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick, extremes, unmoved servo, abandon a long keyframe
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'hFFFF), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_LOAD, '0, 16'd0), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 1, {64'd0, 8'hFF, 1'b1}});
    rows.push_back('{mk_req(ski_pkg::CMD_LOAD, {8{8'd180}}, 16'd0), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 1, {{8{8'd180}}, 8'hFF, 1'b1}});
    rows.push_back('{mk_req(ski_pkg::CMD_LOAD, {8'd255, 8'd201, 8'd181, 8'd90, 8'd179, 8'd1,
                                                8'd0, 8'd180}, 16'd40), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, {8{8'hFF}}, 16'hFFFF), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 1,
                     {8'd255, 8'd201, 8'd181, 8'd90, 8'd179, 8'd1, 8'd0, 8'd180,
                      8'hFF, 1'b1}});
    rows.push_back('{mk_req(ski_pkg::CMD_LOAD, {8'd0, 8'd170, 8'd85, 8'd17, 8'd255, 8'd128,
                                                8'd64, 8'd180}, 16'hFFFF), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_LOAD, {8'd90, 8'd45, 8'd135, 8'd255, 8'd0, 8'd180,
                                                8'd0, 8'd90}, 16'd100), 0, '0});
    repeat (4) rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'd0), 0, '0});
    rows.push_back('{mk_req(ski_pkg::CMD_TICK, '0, 16'h5555), 0, '0});
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].val);

    // Random: keyframe sequences under several register settings
    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(ski_pkg::REG_SPEED, speeds[ph]);
      write_reg(ski_pkg::REG_BASE_DELAY, delays[ph]);
      quiet = (ph == 3);
      if (ph == 2) hold_req = 1;
      while (sent < (ph + 1) * ItemsRandom / 7) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) dur = $urandom_range(0, 400);
        else if (pick < 95) dur = $urandom_range(0, 3000);
        else dur = $urandom();
        send_req(mk_req(ski_pkg::CMD_LOAD, rand_targets(), dur));
        sent++;
        n_tk = tick_tot;
        if (n_tk > 200 || $urandom_range(0, 99) < 12)
          n_tk = $urandom_range(0, (n_tk > 20) ? 20 : n_tk);
        else if ($urandom_range(0, 9) == 0)
          n_tk++;
        repeat (n_tk) begin
          send_req(mk_req(ski_pkg::CMD_TICK, rand_targets(), 16'($urandom())));
          sent++;
        end
        if ($urandom_range(0, 19) == 0) begin
          send_req(mk_req(ski_pkg::CMD_TICK, '0, '0));
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;
    quiet = 0;

    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d loads and %0d ticks over 7 register settings, %0d results taken.",
             n_loads, n_ticks, n_results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
